### rtl/srs_pkg.sv
// srs_pkg: shared constants, types and codes of the substring removal stream
// no dependencies; used by srs_cell, srs_out_buf, substring_removal_stream and the testbench
package srs_pkg;

    localparam int unsigned MAX_PATTERN = 16;
    localparam int unsigned DEPTH       = 16;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W       = $clog2(DEPTH);
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned LEN_W       = 5;

    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [LEN_W-1:0]     t_len;

    localparam t_cfg_idx REG_PAT_LO  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PAT_HI  = t_cfg_idx'(1);
    localparam t_cfg_idx REG_PAT_LEN = t_cfg_idx'(2);

    localparam t_cnt LEN_CAP = t_cnt'((MAX_PATTERN < DEPTH) ? MAX_PATTERN : DEPTH);

    typedef struct packed {
        logic en;
        logic app;
        logic shift;
        logic in_use;
    } t_cell_ctl;

    typedef struct packed {
        t_char char_out;
        logic  char_valid;
        logic  last_out;
    } t_result;

endpackage

### rtl/substring_removal_stream.sv
// substring_removal_stream: top level, removes every occurrence of a pattern from a stream
// depends on srs_pkg, srs_cell and srs_out_buf
//
// usage
//   input words carry one character (or none) and a last flag; output words carry a kept
//   character (or an end-only marker) and a last flag on the final word of a string
//   both channels use valid/stall; a word moves when valid is high and stall is low
//   the pattern (up to 16 bytes) and its length are written through the config port
//   while the block is idle; length zero passes text through unchanged
//   a result is pushed into the output buffer as the word that causes it is taken,
//   unless that word starts a flush or drop as below
//   throughput: one input word per cycle while no flush or drop holds the input and
//   the output buffer has room; the row of 16 byte cells shifts at most once per cycle
//   and compares against the pattern in parallel
//   a last word that leaves n >= 2 bytes to flush holds the input while the window
//   emits one byte per step and then closes the string; its results each wait in a
//   hold register before they go to the output buffer
//   a pattern change in mid-string can hold the input while bytes are emitted or dropped
//   the two-word output buffer keeps input flowing while the receiver stalls until
//   it is full; a full buffer then holds the input off through o_stall
//   reset clears the window count, the buffer and the pattern registers
module substring_removal_stream (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  srs_pkg::t_char                    i_char_in,
    input  logic                              i_has_char,
    input  logic                              i_last_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output srs_pkg::t_char                    o_char_out,
    output logic                              o_char_valid,
    output logic                              o_last_out,
    input  logic                              i_cfg_we,
    input  srs_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [srs_pkg::CFG_W-1:0]     r_pat_lo;
    logic [srs_pkg::CFG_W-1:0]     r_pat_hi;
    srs_pkg::t_len                 r_pat_len;
    logic [2*srs_pkg::CFG_W-1:0]   pat_all;

    srs_pkg::t_cnt    r_cnt, n_cnt;
    srs_pkg::t_cnt    r_drop, n_drop;
    logic             r_busy, n_busy;
    logic             r_last, n_last;
    logic             r_hold_v, n_hold_v;
    srs_pkg::t_char   r_hold, n_hold;

    srs_pkg::t_cnt    len;
    srs_pkg::t_cnt    wcnt;
    logic             buf_full;
    logic             accept;
    logic             act;
    logic             has_in;
    logic             last_cur;
    logic             shift;
    logic             emit;
    logic             work;
    logic             more;
    logic             match_all;
    logic             push_v;
    srs_pkg::t_result push_d;
    srs_pkg::t_result out_d;

    srs_pkg::t_char             eff [srs_pkg::DEPTH];
    logic [srs_pkg::DEPTH-1:0]  ok;
    srs_pkg::t_cell_ctl         ctl [srs_pkg::DEPTH];

    assign pat_all  = {r_pat_hi, r_pat_lo};
    assign len      = (srs_pkg::t_cnt'(r_pat_len) > srs_pkg::LEN_CAP) ?
                      srs_pkg::LEN_CAP : srs_pkg::t_cnt'(r_pat_len);
    assign o_stall  = r_busy || buf_full;
    assign accept   = i_valid && !o_stall;
    assign act      = !buf_full && (r_busy || i_valid);
    assign has_in   = accept && i_has_char;
    assign last_cur = r_busy ? r_last : i_last_in;
    assign wcnt     = r_cnt + srs_pkg::t_cnt'(has_in);
    assign match_all = &ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                srs_pkg::REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                srs_pkg::REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                srs_pkg::REG_PAT_LEN: r_pat_len <= i_cfg_data[srs_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // row of window cells, oldest byte in cell 0
    for (genvar g = 0; g < srs_pkg::DEPTH; g++) begin : g_cell
        srs_pkg::t_char next_b;

        if (g == srs_pkg::DEPTH - 1) begin : g_end
            assign next_b = '0;
        end else begin : g_mid
            assign next_b = eff[g+1];
        end

        assign ctl[g].en     = act;
        assign ctl[g].app    = has_in && (r_cnt[srs_pkg::IDX_W-1:0] == srs_pkg::t_idx'(g));
        assign ctl[g].shift  = shift;
        assign ctl[g].in_use = (srs_pkg::t_cnt'(g) < len);

        srs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl[g]),
            .i_char (i_char_in),
            .i_next (next_b),
            .i_pat  (pat_all[g*srs_pkg::CHAR_W +: srs_pkg::CHAR_W]),
            .o_eff  (eff[g]),
            .o_ok   (ok[g])
        );
    end

    // one window step per cycle while there is input or a flush or drop under way and the output buffer has room
    always_comb begin
        shift  = 1'b0;
        emit   = 1'b0;
        work   = 1'b1;
        n_cnt  = wcnt;
        n_drop = r_drop;
        if (r_drop != '0) begin
            shift  = 1'b1;
            n_cnt  = wcnt - srs_pkg::t_cnt'(1);
            n_drop = r_drop - srs_pkg::t_cnt'(1);
        end else if ((len == '0) && (wcnt != '0)) begin
            shift = 1'b1;
            emit  = 1'b1;
            n_cnt = wcnt - srs_pkg::t_cnt'(1);
        end else if ((len != '0) && (wcnt >= len)) begin
            if (match_all) begin
                if (wcnt == len) begin
                    n_cnt = '0;
                end else begin
                    shift  = 1'b1;
                    n_cnt  = wcnt - srs_pkg::t_cnt'(1);
                    n_drop = len - srs_pkg::t_cnt'(1);
                end
            end else begin
                shift = 1'b1;
                emit  = 1'b1;
                n_cnt = wcnt - srs_pkg::t_cnt'(1);
            end
        end else if (last_cur && (wcnt != '0)) begin
            shift = 1'b1;
            emit  = 1'b1;
            n_cnt = wcnt - srs_pkg::t_cnt'(1);
        end else begin
            work = 1'b0;
        end
        more = (n_drop != '0)
            || ((len == '0) ? (n_cnt != '0) : (n_cnt >= len))
            || (last_cur && (n_cnt != '0));
    end

    // result routing; a word is held back while a string may still end on it
    always_comb begin
        push_v   = 1'b0;
        push_d   = '0;
        n_busy   = r_busy;
        n_last   = r_last;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        if (act) begin
            if (!r_busy) begin
                if (more) begin
                    n_busy   = 1'b1;
                    n_last   = i_last_in;
                    n_hold   = eff[0];
                    n_hold_v = emit;
                end else if (emit) begin
                    push_v = 1'b1;
                    push_d = '{char_out: eff[0], char_valid: 1'b1, last_out: i_last_in};
                end else if (i_last_in) begin
                    push_v = 1'b1;
                    push_d = '{char_out: '0, char_valid: 1'b0, last_out: 1'b1};
                end
            end else if (work) begin
                if (emit) begin
                    push_v   = r_hold_v;
                    push_d   = '{char_out: r_hold, char_valid: 1'b1, last_out: 1'b0};
                    n_hold   = eff[0];
                    n_hold_v = 1'b1;
                end
            end else begin
                n_busy   = 1'b0;
                n_hold_v = 1'b0;
                if (r_hold_v) begin
                    push_v = 1'b1;
                    push_d = '{char_out: r_hold, char_valid: 1'b1, last_out: r_last};
                end else if (r_last) begin
                    push_v = 1'b1;
                    push_d = '{char_out: '0, char_valid: 1'b0, last_out: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_drop   <= '0;
            r_busy   <= 1'b0;
            r_last   <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (act) begin
                r_cnt  <= n_cnt;
                r_drop <= n_drop;
            end
            r_busy   <= n_busy;
            r_last   <= n_last;
            r_hold_v <= n_hold_v;
        end
    end

    srs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_v),
        .i_data  (push_d),
        .i_pop   (!i_stall),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_d)
    );

    assign o_char_out   = out_d.char_out;
    assign o_char_valid = out_d.char_valid;
    assign o_last_out   = out_d.last_out;

endmodule

### rtl/srs_cell.sv
// srs_cell: one byte of the pending window with its pattern compare
// depends on srs_pkg
module srs_cell (
    input  logic               i_clk,
    input  srs_pkg::t_cell_ctl i_ctl,
    input  srs_pkg::t_char     i_char,
    input  srs_pkg::t_char     i_next,
    input  srs_pkg::t_char     i_pat,
    output srs_pkg::t_char     o_eff,
    output logic               o_ok
);

    srs_pkg::t_char r_byte;
    srs_pkg::t_char n_byte;

    // byte as seen this cycle, including a character written here now
    assign o_eff = i_ctl.app ? i_char : r_byte;
    assign o_ok  = !i_ctl.in_use || (o_eff == i_pat);

    always_comb begin
        if (!i_ctl.en) begin
            n_byte = r_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_next;
        end else begin
            n_byte = o_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

### rtl/srs_out_buf.sv
// srs_out_buf: two-word result buffer between the window and the output channel
// depends on srs_pkg
module srs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srs_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output srs_pkg::t_result o_data
);

    srs_pkg::t_result r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             pop_go;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop_go  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop_go) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop_go) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop_go) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### tb/removal_check_pkg.sv
// removal_check_pkg: scoreboard of the substring removal stream testbench
// tracks the pattern registers and pending window, predicts and checks output words
// depends on srs_pkg
package removal_check_pkg;
    import srs_pkg::*;

    class removal_scoreboard;
        t_char       pattern_bytes [DEPTH];
        int unsigned pattern_len;
        t_char       window [$];
        t_result     kept_words [$];
        int          mismatches;
        int          words_checked;

        function new();
            pattern_len   = 0;
            mismatches    = 0;
            words_checked = 0;
            foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_PAT_LO: begin
                    for (int i = 0; i < 8; i++) pattern_bytes[i] = data[8*i +: 8];
                end
                REG_PAT_HI: begin
                    for (int i = 0; i < 8; i++) pattern_bytes[8+i] = data[8*i +: 8];
                end
                REG_PAT_LEN: pattern_len = int'(data[LEN_W-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned active_len();
            if (pattern_len > int'(LEN_CAP)) return int'(LEN_CAP);
            return pattern_len;
        endfunction

        function bit window_is_pattern(int unsigned n);
            for (int i = 0; i < n; i++) begin
                if (window[i] != pattern_bytes[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function t_result kept_char(t_char c);
            t_result r;
            r.char_out   = c;
            r.char_valid = 1'b1;
            r.last_out   = 1'b0;
            return r;
        endfunction

        function void take_source_word(t_char c, logic has, logic last);
            int unsigned n;
            t_result     step_out [$];
            t_result     r;
            n = active_len();
            if (has) begin
                if (window.size() >= DEPTH) begin
                    step_out.push_back(kept_char(window[0]));
                    window.delete(0);
                end
                window.push_back(c);
            end
            if (n == 0) begin
                while (window.size() > 0) begin
                    step_out.push_back(kept_char(window[0]));
                    window.delete(0);
                end
            end else begin
                while (window.size() >= n) begin
                    if (window_is_pattern(n)) begin
                        repeat (n) window.delete(0);
                    end else begin
                        step_out.push_back(kept_char(window[0]));
                        window.delete(0);
                    end
                end
            end
            if (last) begin
                while (window.size() > 0) begin
                    step_out.push_back(kept_char(window[0]));
                    window.delete(0);
                end
                if (step_out.size() == 0) begin
                    r = '0;
                    r.last_out = 1'b1;
                end else begin
                    r = step_out.pop_back();
                    r.last_out = 1'b1;
                end
                step_out.push_back(r);
            end
            foreach (step_out[i]) kept_words.push_back(step_out[i]);
        endfunction

        function void check_kept_word(t_result got);
            t_result want;
            words_checked++;
            if (kept_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: char %02h valid %0b last %0b",
                             got.char_out, got.char_valid, got.last_out);
                return;
            end
            want = kept_words.pop_front();
            if (got.char_out !== want.char_out || got.char_valid !== want.char_valid ||
                got.last_out !== want.last_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: want char %02h valid %0b last %0b, ",
                              "got char %02h valid %0b last %0b"},
                             want.char_out, want.char_valid, want.last_out,
                             got.char_out, got.char_valid, got.last_out);
            end
        endfunction

        function void close_out();
            if (kept_words.size() != 0) begin
                mismatches++;
                $display("%0d expected output words never arrived", kept_words.size());
            end
        endfunction
    endclass

endpackage

### tb/substring_removal_stream_test.sv
// substring_removal_stream_test: top of the substring removal stream testbench
// drives directed and random strings under several patterns and idle patterns
// depends on srs_pkg, removal_check_pkg and the substring_removal_stream rtl
module substring_removal_stream_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srs_pkg::*;
    import removal_check_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 420;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    t_char                i_char_in    = '0;
    logic                 i_has_char   = 1'b0;
    logic                 i_last_in    = 1'b0;
    logic                 i_stall      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    t_cfg_idx             i_cfg_index  = REG_PAT_LO;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_char                o_char_out;
    logic                 o_char_valid;
    logic                 o_last_out;

    removal_scoreboard tracker = new();
    int gap_pct       = 0;
    int stall_pct     = 0;
    int cycles        = 0;
    int settings_used = 0;
    int source_words  = 0;

    substring_removal_stream DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_in    (i_char_in),
        .i_has_char   (i_has_char),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_out   (o_char_out),
        .o_char_valid (o_char_valid),
        .o_last_out   (o_last_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            tracker.check_kept_word(t_result'({o_char_out, o_char_valid, o_last_out}));
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_char alpha_char();
        case ($urandom_range(3))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [LEN_W-1:0] len);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_PAT_LEN, CFG_W'(len));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_word(t_char c, logic has, logic last);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid    <= 1'b1;
        i_char_in  <= c;
        i_has_char <= has;
        i_last_in  <= last;
        do @(posedge i_clk); while (o_stall);
        tracker.take_source_word(c, has, last);
        if (has || last) source_words++;
    endtask

    // idle once every expected word is out, then let a flush or drop finish
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.kept_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setting(int forced_len);
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [LEN_W-1:0] len;
        case ($urandom_range(5))
            0: begin lo = '0; hi = '0; end
            1: begin lo = '1; hi = '1; end
            2: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
            default: begin
                for (int i = 0; i < 8; i++) begin
                    lo[8*i +: 8] = alpha_char();
                    hi[8*i +: 8] = alpha_char();
                end
            end
        endcase
        case ($urandom_range(19))
            0: len = '0;
            1, 2: len = LEN_W'(16);
            3: len = LEN_W'($urandom_range(31, 17));
            default: len = LEN_W'($urandom_range(15, 1));
        endcase
        if (forced_len >= 0) len = LEN_W'(forced_len);
        load_pattern(lo, hi, len);
    endtask

    // mostly pattern copies and pieces of them, some strings left open
    task automatic send_string();
        int unsigned n;
        int unsigned text_len;
        int unsigned pick;
        bit          ends;
        bit          own_end;
        t_char       text [$];
        n        = tracker.active_len();
        text_len = $urandom_range(24);
        while (text.size() < text_len) begin
            pick = $urandom_range(99);
            if (n > 0 && pick < 30) begin
                for (int i = 0; i < n; i++) text.push_back(tracker.pattern_bytes[i]);
            end else if (n > 1 && pick < 40) begin
                for (int i = 0; i + 1 < n; i++) text.push_back(tracker.pattern_bytes[i]);
            end else if (n > 0 && pick < 70) begin
                text.push_back(tracker.pattern_bytes[$urandom_range(n - 1)]);
            end else if (pick < 85) begin
                text.push_back(alpha_char());
            end else begin
                text.push_back(t_char'($urandom_range(255)));
            end
        end
        ends    = ($urandom_range(9) != 0);
        own_end = (text.size() == 0) || ($urandom_range(3) == 0);
        foreach (text[i]) begin
            if ($urandom_range(19) == 0) send_word(t_char'($urandom_range(255)), 1'b0, 1'b0);
            send_word(text[i], 1'b1, ends && !own_end && i == text.size() - 1);
        end
        if (ends && own_end) send_word(t_char'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        int phase_goal;
        int setting_goal;
        bit first;
        gap_pct   = 13;
        stall_pct = 80;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass through after reset, zero bytes, empty end
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        settle();

        // two-byte pattern, one byte left pending, then pattern changed under it
        load_pattern(64'h6261, 64'h0, LEN_W'(2));
        send_word(8'h78, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        settle();
        load_pattern(64'h6261, 64'h0, LEN_W'(0));
        send_word(8'h33, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        settle();

        // oversized length saturates to a full 16-byte window match
        load_pattern('1, '0, '1);
        send_word(8'h71, 1'b1, 1'b0);
        for (int i = 0; i < 16; i++) send_word((i < 8) ? 8'hFF : 8'h00, 1'b1, i == 15);

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin gap_pct = 13; stall_pct = 80; end
                1: begin gap_pct = 80; stall_pct = 13; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            phase_goal = source_words + RANDOM_WORDS / 3;
            first      = 1'b1;
            while (source_words < phase_goal) begin
                settle();
                if (first) random_setting(regime == 0 ? 16 : (regime == 1 ? 1 : -1));
                else random_setting(-1);
                first        = 1'b0;
                setting_goal = source_words + $urandom_range(50, 20);
                while (source_words < setting_goal) send_string();
            end
        end

        settle();
        tracker.close_out();
        $display("covered %0d source words under %0d pattern settings,",
                 source_words, settings_used);
        $display("%0d output words checked", tracker.words_checked);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
